// File: design/imh_pkg.sv
// ----------------------------------------------------------------------------
// imh_pkg
// Shared types, codes and the command/status bundles of the indexed max-heap.
// ----------------------------------------------------------------------------
package imh_pkg;

    localparam int ID_W  = 8;
    localparam int KEY_W = 32;
    localparam int NUM_IDS = 256;

    typedef enum logic [1:0] {
        FN_INSERT   = 2'd0,
        FN_DELMAX   = 2'd1,
        FN_INCKEY   = 2'd2,
        FN_NONE     = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_FULL    = 3'd1,
        ST_EMPTY   = 3'd2,
        ST_ABSENT  = 3'd3,
        ST_PRESENT = 3'd4
    } t_status;

    typedef struct packed {
        logic [1:0]             func;
        logic [ID_W-1:0]        item_id;
        logic signed [KEY_W-1:0] new_key;
    } t_in;

    typedef struct packed {
        logic [2:0]             status;
        logic [ID_W-1:0]        out_id;
        logic signed [KEY_W-1:0] out_key;
        logic [8:0]             entry_count;
        logic                   is_empty;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_INS_WR,
        S_INC_RD,
        S_INC_WR,
        S_DEL_RD,
        S_DEL_MV,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RD,
        S_DN_CMP,
        S_SWAP_A,
        S_SWAP_B,
        S_DONE
    } t_state;

    // controller -> datapath: one command per cycle
    typedef enum logic [3:0] {
        C_NOP,
        C_LOAD,
        C_INS_WR,
        C_INC_RD,
        C_INC_WR,
        C_DEL_RD,
        C_DEL_MV,
        C_UP_RD,
        C_DN_RD,
        C_UP_SEL,
        C_DN_SEL,
        C_SWAP_A,
        C_SWAP_B,
        C_FINISH
    } t_cmd;

    typedef struct packed {
        logic        full;
        logic        empty;
        logic        present;
        logic        inc_ok;
        logic        at_root;
        logic        up_swap;
        logic        dn_swap;
        logic        del_last;
        logic [1:0]  func;
    } t_stat;

endpackage

// File: design/imh_ram.sv
// ----------------------------------------------------------------------------
// imh_ram
// Single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module imh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: design/imh_ctrl.sv
// ----------------------------------------------------------------------------
// imh_ctrl
// Operation sequencer: handshake, decode, sift-up and sift-down loops.
// ----------------------------------------------------------------------------
module imh_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  imh_pkg::t_stat  i_stat,
    output imh_pkg::t_cmd   o_cmd
);
    import imh_pkg::*;

    t_state r_state, n_state;
    logic   r_dn, n_dn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dn    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dn    <= n_dn;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_dn        = r_dn;
        o_cmd       = C_NOP;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd   = C_LOAD;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_DONE;
                o_cmd   = C_FINISH;
                case (i_stat.func)
                    FN_INSERT: begin
                        if (!i_stat.full && !i_stat.present) begin
                            o_cmd   = C_INS_WR;
                            n_state = S_INS_WR;
                        end
                    end
                    FN_DELMAX: begin
                        if (!i_stat.empty) begin
                            o_cmd   = C_DEL_RD;
                            n_state = S_DEL_RD;
                        end
                    end
                    FN_INCKEY: begin
                        if (i_stat.present) begin
                            // wait for the position read
                            o_cmd   = C_NOP;
                            n_state = S_INC_RD;
                        end
                    end
                    default: ;
                endcase
            end
            S_INS_WR: begin
                n_dn = 1'b0;
                o_cmd = C_UP_RD;
                n_state = S_UP_RD;
            end
            S_INC_RD: begin
                // key read lands next cycle
                o_cmd   = C_INC_RD;
                n_state = S_INC_WR;
            end
            S_INC_WR: begin
                if (i_stat.inc_ok) begin
                    o_cmd   = C_INC_WR;
                    n_dn    = 1'b0;
                    n_state = S_UP_RD;
                end else begin
                    o_cmd   = C_FINISH;
                    n_state = S_DONE;
                end
            end
            S_DEL_RD: begin
                o_cmd   = C_DEL_RD;
                n_state = S_DEL_MV;
            end
            S_DEL_MV: begin
                o_cmd = C_DEL_MV;
                n_dn  = 1'b1;
                if (i_stat.del_last) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_DN_RD;
                end
            end
            S_UP_RD: begin
                if (i_stat.at_root) begin
                    o_cmd   = C_FINISH;
                    n_state = S_DONE;
                end else begin
                    o_cmd   = C_UP_RD;
                    n_state = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (i_stat.up_swap) begin
                    o_cmd   = C_UP_SEL;
                    n_state = S_SWAP_A;
                end else begin
                    o_cmd   = C_FINISH;
                    n_state = S_DONE;
                end
            end
            S_DN_RD: begin
                o_cmd   = C_DN_RD;
                n_state = S_DN_CMP;
            end
            S_DN_CMP: begin
                if (i_stat.dn_swap) begin
                    o_cmd   = C_DN_SEL;
                    n_state = S_SWAP_A;
                end else begin
                    o_cmd   = C_FINISH;
                    n_state = S_DONE;
                end
            end
            S_SWAP_A: begin
                o_cmd   = C_SWAP_A;
                n_state = S_SWAP_B;
            end
            S_SWAP_B: begin
                o_cmd   = C_SWAP_B;
                n_state = r_dn ? S_DN_RD : S_UP_RD;
            end
            S_DONE: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

// File: design/imh_dp.sv
// ----------------------------------------------------------------------------
// imh_dp
// Heap storage, position table, present bits, fill count and result register.
// ----------------------------------------------------------------------------
module imh_dp #(
    parameter int CAPACITY = 256
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  imh_pkg::t_in   i_in,
    input  imh_pkg::t_cmd  i_cmd,
    output imh_pkg::t_stat o_stat,
    output imh_pkg::t_out  o_out
);
    import imh_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    // slot memory: id and key of each slot, two read ports via two copies
    logic          s_we;
    logic [AW-1:0] s_wa, s_ra0, s_ra1;
    logic [ID_W+KEY_W-1:0] s_wd, s_rd0, s_rd1;
    logic          p_we;
    logic [ID_W-1:0] p_wa;
    logic [AW-1:0] p_wd, p_rd;

    logic [NUM_IDS-1:0]    r_present;
    logic [CW-1:0]         r_count;
    t_in                   r_req;
    logic [AW-1:0]         r_node, r_other;
    logic [ID_W-1:0]       r_aid, r_bid;
    logic signed [KEY_W-1:0] r_akey, r_bkey;
    t_out                  r_out;
    t_out                  load_out;

    logic signed [KEY_W-1:0] k0, k1;
    logic [ID_W-1:0]         d0, d1;
    logic [CW:0]             lc, rc;
    logic                    l_ok, r_ok, r_wins;
    logic signed [KEY_W-1:0] best_k;

    imh_ram #(.WIDTH(ID_W + KEY_W), .DEPTH(CAPACITY)) u_slot0 (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_wa), .i_wdata(s_wd),
        .i_raddr(s_ra0), .o_rdata(s_rd0));
    imh_ram #(.WIDTH(ID_W + KEY_W), .DEPTH(CAPACITY)) u_slot1 (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_wa), .i_wdata(s_wd),
        .i_raddr(s_ra1), .o_rdata(s_rd1));
    imh_ram #(.WIDTH(AW), .DEPTH(NUM_IDS)) u_pos (
        .i_clk(i_clk), .i_we(p_we), .i_waddr(p_wa), .i_wdata(p_wd),
        .i_raddr(r_req.item_id), .o_rdata(p_rd));

    assign {d0, k0} = s_rd0;
    assign {d1, k1} = s_rd1;
    assign lc   = (CW+1)'({r_node, 1'b1});
    assign rc   = lc + 1'b1;
    assign l_ok = lc < {1'b0, r_count};
    assign r_ok = rc < {1'b0, r_count};
    // node in r_akey; left child on port 0, right on port 1
    assign r_wins = r_ok && (l_ok ? (k1 > k0) : 1'b0);
    assign best_k = r_wins ? k1 : k0;

    always_comb begin
        o_stat.full     = r_count >= CW'(CAPACITY);
        o_stat.empty    = r_count == '0;
        o_stat.present  = r_present[r_req.item_id];
        o_stat.inc_ok   = !(k0 > r_req.new_key);
        o_stat.at_root  = r_node == '0;
        o_stat.up_swap  = r_akey > k0;
        o_stat.dn_swap  = l_ok && (best_k > r_akey);
        o_stat.del_last = r_count == CW'(1);
        o_stat.func     = r_req.func;
    end

    // status of the incoming transaction, judged on the state before it
    always_comb begin
        load_out = '0;
        case (i_in.func)
            FN_INSERT: begin
                if (o_stat.full) begin
                    load_out.status = ST_FULL;
                end else if (r_present[i_in.item_id]) begin
                    load_out.status = ST_PRESENT;
                end
            end
            FN_DELMAX: begin
                if (o_stat.empty) begin
                    load_out.status = ST_EMPTY;
                end
            end
            FN_INCKEY: begin
                if (!r_present[i_in.item_id]) begin
                    load_out.status = ST_ABSENT;
                end
            end
            default: ;
        endcase
    end

    // read address steering
    always_comb begin
        s_ra0 = r_node;
        s_ra1 = r_node;
        case (i_cmd)
            C_INC_RD: s_ra0 = p_rd;
            C_DEL_RD: begin
                s_ra0 = '0;
                s_ra1 = AW'(r_count - 1'b1);
            end
            C_UP_RD:  s_ra0 = AW'((r_node - 1'b1) >> 1);
            C_DN_RD: begin
                s_ra0 = AW'({r_node, 1'b1});
                s_ra1 = AW'({r_node, 1'b1} + 1'b1);
            end
            default: ;
        endcase
    end

    // write steering
    always_comb begin
        s_we = 1'b0;
        s_wa = r_node;
        s_wd = {r_aid, r_akey};
        p_we = 1'b0;
        p_wa = r_aid;
        p_wd = r_node;
        case (i_cmd)
            C_INS_WR: begin
                s_we = 1'b1;
                s_wa = AW'(r_count);
                s_wd = {r_req.item_id, r_req.new_key};
                p_we = 1'b1;
                p_wa = r_req.item_id;
                p_wd = AW'(r_count);
            end
            C_INC_WR: begin
                s_we = 1'b1;
                s_wa = p_rd;
                s_wd = {d0, r_req.new_key};
            end
            C_DEL_MV: begin
                s_we = 1'b1;
                s_wa = '0;
                s_wd = s_rd1;
                p_we = 1'b1;
                p_wa = d1;
                p_wd = '0;
            end
            C_SWAP_A: begin
                s_we = 1'b1;
                s_wa = r_other;
                s_wd = {r_aid, r_akey};
                p_we = 1'b1;
                p_wa = r_aid;
                p_wd = r_other;
            end
            C_SWAP_B: begin
                s_we = 1'b1;
                s_wa = r_node;
                s_wd = {r_bid, r_bkey};
                p_we = 1'b1;
                p_wa = r_bid;
                p_wd = r_node;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= '0;
            r_count   <= '0;
        end else begin
            case (i_cmd)
                C_INS_WR: begin
                    r_present[r_req.item_id] <= 1'b1;
                    r_count <= r_count + 1'b1;
                end
                C_DEL_MV: begin
                    r_present[d0] <= 1'b0;
                    r_count <= r_count - 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd)
            C_LOAD: begin
                r_req <= i_in;
                r_out <= load_out;
            end
            C_INS_WR: begin
                r_node <= AW'(r_count);
                r_aid  <= r_req.item_id;
                r_akey <= r_req.new_key;
            end
            C_INC_WR: begin
                r_node <= p_rd;
                r_aid  <= d0;
                r_akey <= r_req.new_key;
            end
            C_DEL_MV: begin
                r_out.out_id  <= d0;
                r_out.out_key <= k0;
                r_node <= '0;
                r_aid  <= d1;
                r_akey <= k1;
            end
            C_UP_SEL: begin
                r_other <= AW'((r_node - 1'b1) >> 1);
                r_bid   <= d0;
                r_bkey  <= k0;
            end
            C_DN_SEL: begin
                r_other <= r_wins ? AW'(rc) : AW'(lc);
                r_bid   <= r_wins ? d1 : d0;
                r_bkey  <= best_k;
            end
            C_SWAP_B: begin
                r_node <= r_other;
            end
            default: ;
        endcase
    end

    always_comb begin
        o_out             = r_out;
        o_out.entry_count = 9'(r_count);
        o_out.is_empty    = r_count == '0;
    end
endmodule

// File: design/indexed_max_heap.sv
// A rejected or unused operation goes from decode straight to the result;
// each level swapped during a sift passes through the read, compare, swap-A
// and swap-B states.
// Throughput: one operation at a time; the next accept follows the result.
// Reset: synchronous, active low; clears the fill count and the present bits.
// ----------------------------------------------------------------------------
// indexed_max_heap
// Indexed binary max-heap with insert, delete-max and increase-key.
// ----------------------------------------------------------------------------
module indexed_max_heap #(
    parameter int CAPACITY = 256
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  imh_pkg::t_in   i_in,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output imh_pkg::t_out  o_out
);
    import imh_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    imh_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready), .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready), .i_stat(stat), .o_cmd(cmd));

    imh_dp #(.CAPACITY(CAPACITY)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(i_in), .i_cmd(cmd),
        .o_stat(stat), .o_out(o_out));
endmodule

// File: design/imh_checker.sv
// ----------------------------------------------------------------------------
// imh_checker
// Port-level checks of the indexed max-heap.
// ----------------------------------------------------------------------------
module imh_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_in_ready,
    input logic          i_in_valid,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input imh_pkg::t_out o_out
);
    import imh_pkg::*;

    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid)) else $error("ready while result pending");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready right after accept");
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.is_empty == (o_out.entry_count == 9'd0)))
        else $error("empty flag mismatch");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result dropped");
    a_noid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status != ST_OK |-> o_out.out_id == '0)
        else $error("id on failure");
endmodule

bind indexed_max_heap imh_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_in_ready(o_in_ready),
    .i_in_valid(i_in_valid), .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready), .o_out(o_out));

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for indexed_max_heap: a queue-fed driver offers
// insert, delete-max, increase-key and unused operations, a heap predictor
// computes each response, and a monitor compares every whole response.
// ----------------------------------------------------------------------------
module tb;
    import imh_pkg::*;

    localparam int CAP      = 256;
    localparam int MAX_CYC  = 2000000;
    localparam int MAX_ERRS = 10;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_in_valid;
    logic  o_in_ready;
    t_in   i_in;
    logic  o_out_valid;
    logic  i_out_ready;
    t_out  o_out;

    indexed_max_heap #(.CAPACITY(CAP)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    t_in  op_queue[$];
    t_out resp_queue[$];

    logic [ID_W-1:0]  hp_ids  [CAP];
    logic [KEY_W-1:0] hp_keys [CAP];
    int               hp_pos  [NUM_IDS];
    bit               hp_live [NUM_IDS];
    int               hp_fill;

    int  cycle_cnt;
    int  mismatch_cnt;
    int  resp_cnt;
    int  sent_cnt;
    int  hold_cycles;
    bit  calm;
    bit  stim_done;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic bit key_gt(logic [KEY_W-1:0] a, logic [KEY_W-1:0] b);
        return $signed(a) > $signed(b);
    endfunction

    function automatic void heap_swap(int x, int y);
        logic [ID_W-1:0]  ti;
        logic [KEY_W-1:0] tk;
        ti = hp_ids[x];
        tk = hp_keys[x];
        hp_ids[x] = hp_ids[y];
        hp_keys[x] = hp_keys[y];
        hp_ids[y] = ti;
        hp_keys[y] = tk;
        hp_pos[hp_ids[x]] = x;
        hp_pos[hp_ids[y]] = y;
    endfunction

    function automatic void heap_up(int node);
        int up;
        while (node != 0) begin
            up = (node - 1) / 2;
            if (!key_gt(hp_keys[node], hp_keys[up])) break;
            heap_swap(node, up);
            node = up;
        end
    endfunction

    function automatic void heap_down(int node);
        int best;
        int l;
        int r;
        forever begin
            best = node;
            l = node * 2 + 1;
            r = node * 2 + 2;
            if (l < hp_fill && key_gt(hp_keys[l], hp_keys[best])) best = l;
            if (r < hp_fill && key_gt(hp_keys[r], hp_keys[best])) best = r;
            if (best == node) break;
            heap_swap(node, best);
            node = best;
        end
    endfunction

    function automatic t_out heap_apply(t_in op);
        t_out r;
        int   s;
        int   p;
        r = '0;
        r.status = ST_OK;
        case (t_func'(op.func))
            FN_INSERT: begin
                if (hp_fill >= CAP) r.status = ST_FULL;
                else if (hp_live[op.item_id]) r.status = ST_PRESENT;
                else begin
                    s = hp_fill;
                    hp_ids[s] = op.item_id;
                    hp_keys[s] = op.new_key;
                    hp_pos[op.item_id] = s;
                    hp_live[op.item_id] = 1'b1;
                    hp_fill = s + 1;
                    heap_up(s);
                end
            end
            FN_DELMAX: begin
                if (hp_fill == 0) r.status = ST_EMPTY;
                else begin
                    r.out_id = hp_ids[0];
                    r.out_key = hp_keys[0];
                    heap_swap(0, hp_fill - 1);
                    hp_fill--;
                    hp_live[r.out_id] = 1'b0;
                    heap_down(0);
                end
            end
            FN_INCKEY: begin
                if (!hp_live[op.item_id]) r.status = ST_ABSENT;
                else begin
                    p = hp_pos[op.item_id];
                    if (p < hp_fill && !key_gt(hp_keys[p], op.new_key)) begin
                        hp_keys[p] = op.new_key;
                        heap_up(p);
                    end
                end
            end
            default: ;
        endcase
        r.entry_count = hp_fill[8:0];
        r.is_empty = (hp_fill == 0);
        return r;
    endfunction

    function automatic t_in mk_op(t_func f, int id, logic [KEY_W-1:0] k);
        t_in o;
        o.func = f;
        o.item_id = id[ID_W-1:0];
        o.new_key = k;
        return o;
    endfunction

    // stimulus
    initial begin
        int n;
        int pick;
        op_queue.push_back(mk_op(FN_DELMAX, 0, 0));
        op_queue.push_back(mk_op(FN_INCKEY, 7, 5));
        op_queue.push_back(mk_op(FN_INSERT, 0, 32'h8000_0000));
        op_queue.push_back(mk_op(FN_INSERT, 255, 32'h7fff_ffff));
        op_queue.push_back(mk_op(FN_INSERT, 255, 3));
        op_queue.push_back(mk_op(FN_INSERT, 10, 100));
        op_queue.push_back(mk_op(FN_INSERT, 11, 100));
        op_queue.push_back(mk_op(FN_INSERT, 12, 100));
        op_queue.push_back(mk_op(FN_INCKEY, 10, 50));
        op_queue.push_back(mk_op(FN_INCKEY, 11, 100));
        op_queue.push_back(mk_op(FN_INCKEY, 0, 32'h7fff_ffff));
        op_queue.push_back(mk_op(FN_NONE, 170, 32'h5555_aaaa));
        op_queue.push_back(mk_op(FN_NONE, 85, 32'haaaa_5555));
        for (int i = 0; i < 7; i++) op_queue.push_back(mk_op(FN_DELMAX, 0, 0));
        for (int i = 0; i < 256; i++)
            op_queue.push_back(mk_op(FN_INSERT, i, $urandom_range(0, 15) - 8));
        op_queue.push_back(mk_op(FN_INSERT, 3, 1));
        op_queue.push_back(mk_op(FN_INCKEY, 200, 32'h7fff_ffff));
        for (int i = 0; i < 256; i++) op_queue.push_back(mk_op(FN_DELMAX, 0, 0));
        n = 0;
        while (n < 1116) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                op_queue.push_back(mk_op(FN_INSERT, $urandom_range(0, 255),
                    ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 40) - 20));
            end else if (pick < 75) begin
                op_queue.push_back(mk_op(FN_DELMAX, $urandom_range(0, 255), $urandom));
            end else if (pick < 97) begin
                op_queue.push_back(mk_op(FN_INCKEY, $urandom_range(0, 255),
                    ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 60) - 20));
            end else begin
                op_queue.push_back(mk_op(FN_NONE, $urandom_range(0, 255), $urandom));
            end
            n++;
        end
        stim_done = 1'b1;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_in <= '0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                resp_queue.push_back(heap_apply(i_in));
                sent_cnt <= sent_cnt + 1;
            end
            if ((!i_in_valid || o_in_ready) && op_queue.size() > 0 &&
                (calm || $urandom_range(0, 99) >= 25)) begin
                i_in <= op_queue.pop_front();
                i_in_valid <= 1'b1;
            end else if (!i_in_valid || o_in_ready) begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // output hold-off and a calm window without random stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            hold_cycles <= 0;
            calm <= 1'b0;
        end else begin
            calm <= (sent_cnt > 700 && sent_cnt < 1000);
            if (sent_cnt > 300 && sent_cnt < 320 && hold_cycles == 0)
                hold_cycles <= 400;
            else if (hold_cycles > 1)
                hold_cycles <= hold_cycles - 1;
            if (hold_cycles > 1)
                i_out_ready <= 1'b0;
            else
                i_out_ready <= calm || ($urandom_range(0, 99) >= 25);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out exp_r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            resp_cnt <= resp_cnt + 1;
            if (resp_queue.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_ERRS)
                    $display("unexpected transaction: %p", o_out);
            end else begin
                exp_r = resp_queue.pop_front();
                if (o_out !== exp_r) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_ERRS)
                        $display("mismatch: expected %p actual %p", exp_r, o_out);
                end
            end
        end
    end

    initial begin
        cycle_cnt = 0;
        mismatch_cnt = 0;
        resp_cnt = 0;
        sent_cnt = 0;
        for (int i = 0; i < NUM_IDS; i++) begin
            hp_live[i] = 1'b0;
            hp_pos[i] = 0;
        end
        hp_fill = 0;
    end

    // end of run
    initial begin
        @(posedge i_rst_n);
        while (!(stim_done && op_queue.size() == 0 && !i_in_valid &&
                 resp_queue.size() == 0) && cycle_cnt < MAX_CYC) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        if (cycle_cnt >= MAX_CYC) begin
            $display("indexed_max_heap verification failed");
            $finish;
        end else begin
            repeat (100) @(posedge i_clk);
            $display("covered %0d transactions (insert, delete-max, increase-key, unused)",
                     resp_cnt);
            $display("including full/empty heap, duplicate and absent ids, ties, stalls");
            if (mismatch_cnt == 0 && resp_queue.size() == 0)
                $display("indexed_max_heap verification clean");
            else
                $display("indexed_max_heap verification failed");
            $finish;
        end
    end
endmodule
